// File: rtl/crcfe_pkg.sv
// Package for the CRC-16 message frame encoder: command type, codes, constants
// and the byte-wise CRC-16/CCITT-FALSE update. No dependencies.
`timescale 1ns / 1ps
package crcfe_pkg;

  // Largest accepted payload length of one frame
  localparam logic [7:0] MAX_PAYLOAD = 8'd64;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Reset values of the configuration registers
  localparam logic [7:0] SYNC_FIRST_RST  = 8'h53;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h45;
  localparam logic [7:0] VERSION_RST     = 8'h02;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_VERSION     = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_TOPIC = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;

  // Byte positions inside one frame
  localparam logic [2:0] STEP_SYNC1   = 3'd0;
  localparam logic [2:0] STEP_SYNC2   = 3'd1;
  localparam logic [2:0] STEP_VERSION = 3'd2;
  localparam logic [2:0] STEP_TOPIC   = 3'd3;
  localparam logic [2:0] STEP_LEN     = 3'd4;
  localparam logic [2:0] STEP_DATA    = 3'd5;
  localparam logic [2:0] STEP_CRC_LO  = 3'd6;
  localparam logic [2:0] STEP_CRC_HI  = 3'd7;

  typedef enum logic [1:0] {
    K_START,
    K_MID,
    K_ERR_TOPIC,
    K_ERR_LEN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  topic;
    logic [7:0]  frame_length;
    logic [7:0]  data_byte;
    logic        last;
  } cmd_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/crcfe_front.sv
// Front end of the frame encoder: accepts input items, checks frame starts
// and tracks payload bytes left. Depends on crcfe_pkg.
`timescale 1ns / 1ps
module crcfe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         topic_i,
  input  logic [7:0]         frame_length_i,
  input  logic [7:0]         data_byte_i,
  input  crcfe_pkg::q_stat_t q_stat_i,
  output logic               in_ready_o,
  output logic               push_o,
  output crcfe_pkg::cmd_t    cmd_o
);
  import crcfe_pkg::*;

  logic [7:0] remaining_q, remaining_d;

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    remaining_d        = remaining_q;
    cmd_o.topic        = topic_i;
    cmd_o.frame_length = frame_length_i;
    cmd_o.data_byte    = data_byte_i;
    cmd_o.last         = 1'b0;
    cmd_o.kind         = K_MID;
    if (remaining_q == 8'd0) begin
      if (topic_i == 8'd0) begin
        cmd_o.kind = K_ERR_TOPIC;
      end else if (frame_length_i == 8'd0 || frame_length_i > MAX_PAYLOAD) begin
        cmd_o.kind = K_ERR_LEN;
      end else begin
        cmd_o.kind  = K_START;
        cmd_o.last  = (frame_length_i == 8'd1);
        remaining_d = frame_length_i - 8'd1;
      end
    end else begin
      cmd_o.last  = (remaining_q == 8'd1);
      remaining_d = remaining_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= 8'd0;
    end else if (push_o) begin
      remaining_q <= remaining_d;
    end
  end

endmodule

// File: rtl/crcfe_queue.sv
// Two-entry command queue between front and back of the frame encoder.
// Depends on crcfe_pkg.
`timescale 1ns / 1ps
module crcfe_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  crcfe_pkg::cmd_t    push_cmd_i,
  input  logic               pop_i,
  output crcfe_pkg::cmd_t    head_o,
  output crcfe_pkg::q_stat_t stat_o
);
  import crcfe_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/crcfe_back.sv
// Back end of the frame encoder: sequences frame bytes, runs the CRC, keeps
// the counters and holds the output register. Depends on crcfe_pkg.
`timescale 1ns / 1ps
module crcfe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crcfe_pkg::cmd_t    head_i,
  input  crcfe_pkg::q_stat_t q_stat_i,
  output logic               pop_o,
  input  logic [7:0]         sync_first_i,
  input  logic [7:0]         sync_second_i,
  input  logic [7:0]         version_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic [1:0]         status_o,
  output logic               run_last_o,
  output logic               frame_end_o,
  output logic [31:0]        frames_sent_o,
  output logic [31:0]        bytes_sent_o
);
  import crcfe_pkg::*;

  logic        started_q;
  logic [2:0]  step_q;
  logic [15:0] crc_q, crc_d;
  logic [31:0] frames_q, frames_d;
  logic [31:0] bytes_q, bytes_d;

  logic        vld_q;
  logic [7:0]  byte_q, byte_d;
  logic [1:0]  status_q, status_d;
  logic        last_q, last_d;
  logic        fend_q, fend_d;
  logic [31:0] ofr_q, obt_q;

  logic        issue, is_err, final_step;
  logic [2:0]  eff_step;

  assign is_err   = (head_i.kind == K_ERR_TOPIC) || (head_i.kind == K_ERR_LEN);
  assign issue    = !q_stat_i.empty && (!vld_q || out_ready_i);
  assign eff_step = started_q ? step_q :
                    ((head_i.kind == K_MID) ? STEP_DATA : STEP_SYNC1);
  assign final_step = is_err ||
                      (head_i.last ? (eff_step == STEP_CRC_HI) : (eff_step == STEP_DATA));
  assign pop_o    = issue && final_step;

  always_comb begin
    byte_d   = 8'd0;
    status_d = ST_OK;
    last_d   = final_step;
    fend_d   = 1'b0;
    crc_d    = crc_q;
    frames_d = frames_q;
    bytes_d  = bytes_q;
    if (is_err) begin
      status_d = (head_i.kind == K_ERR_TOPIC) ? ST_BAD_TOPIC : ST_BAD_LEN;
    end else begin
      bytes_d = bytes_q + 32'd1;
      case (eff_step)
        STEP_SYNC1: begin
          byte_d = sync_first_i;
          crc_d  = CRC_INIT;
        end
        STEP_SYNC2:   byte_d = sync_second_i;
        STEP_VERSION: byte_d = version_i;
        STEP_TOPIC:   byte_d = head_i.topic;
        STEP_LEN:     byte_d = head_i.frame_length;
        STEP_DATA:    byte_d = head_i.data_byte;
        STEP_CRC_LO:  byte_d = crc_q[7:0];
        STEP_CRC_HI: begin
          byte_d   = crc_q[15:8];
          fend_d   = 1'b1;
          frames_d = frames_q + 32'd1;
        end
        default:      byte_d = 8'd0;
      endcase
      // version, topic, length and payload are covered by the CRC
      if (eff_step == STEP_VERSION || eff_step == STEP_TOPIC ||
          eff_step == STEP_LEN || eff_step == STEP_DATA) begin
        crc_d = crc_upd(crc_q, byte_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      step_q    <= STEP_SYNC1;
      crc_q     <= CRC_INIT;
      frames_q  <= 32'd0;
      bytes_q   <= 32'd0;
      vld_q     <= 1'b0;
    end else begin
      if (issue) begin
        vld_q    <= 1'b1;
        crc_q    <= crc_d;
        frames_q <= frames_d;
        bytes_q  <= bytes_d;
        if (final_step) begin
          started_q <= 1'b0;
        end else begin
          started_q <= 1'b1;
          step_q    <= eff_step + 3'd1;
        end
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      byte_q   <= byte_d;
      status_q <= status_d;
      last_q   <= last_d;
      fend_q   <= fend_d;
      ofr_q    <= frames_d;
      obt_q    <= bytes_d;
    end
  end

  assign out_valid_o   = vld_q;
  assign out_byte_o    = byte_q;
  assign status_o      = status_q;
  assign run_last_o    = last_q;
  assign frame_end_o   = fend_q;
  assign frames_sent_o = ofr_q;
  assign bytes_sent_o  = obt_q;

endmodule

// File: rtl/crc16_message_frame_encoder.sv
// Top level of the CRC-16 message frame encoder: configuration registers and
// the front / queue / back chain. Depends on crcfe_pkg, crcfe_front,
// crcfe_queue and crcfe_back.
`timescale 1ns / 1ps
//
// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid/tready   | tdata: topic, frame_length, data_byte
// m_axis    | out | m_axis_tvalid/tready   | tdata: out_byte, frames_sent, bytes_sent;
//           |     |                        | tuser: status, frame_end; tlast: run_last
// cfg       | in  | cfg_we_i (no stall)    | cfg_idx_i, cfg_data_i
//
// A mid-frame payload item yields a single result, so payload streams at one item per
// cycle while the output is not stalled. The first item of a frame yields six results
// and the last one three, so the single output byte lane of the back end sets the rate
// there: one result per cycle when not stalled, at most eight results per item
// (one-byte frame). The two-entry command queue lets the front accept up to two items
// ahead while the output stalls. Each result is built from the command at the head of
// the queue and held in the back end's output register. Reset is asynchronous and
// clears all control state, counters and configuration to their defaults.
module crc16_message_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] topic, [15:8] frame_length, [23:16] data_byte
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [7:0] out_byte, [39:8] frames_sent, [71:40] bytes_sent
  output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] frame_end
  output logic        m_axis_tlast,   // run_last
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import crcfe_pkg::*;

  logic [7:0] sync_first_q, sync_second_q, version_q;

  cmd_t    push_cmd, head_cmd;
  logic    push, pop;
  q_stat_t q_stat;

  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic        frame_end;
  logic [31:0] frames_sent, bytes_sent;

  // Configuration registers; an index past the last register is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      version_q     <= VERSION_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        CFG_VERSION:     version_q     <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Classify each item and track the payload bytes left in the frame
  crcfe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .topic_i        (s_axis_tdata[7:0]),
    .frame_length_i (s_axis_tdata[15:8]),
    .data_byte_i    (s_axis_tdata[23:16]),
    .q_stat_i       (q_stat),
    .in_ready_o     (s_axis_tready),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  // Decouple item acceptance from byte emission
  crcfe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .stat_o     (q_stat)
  );

  // Emit header, payload and CRC bytes, one per cycle while the output is not stalled
  crcfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .version_i     (version_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (out_byte),
    .status_o      (status),
    .run_last_o    (m_axis_tlast),
    .frame_end_o   (frame_end),
    .frames_sent_o (frames_sent),
    .bytes_sent_o  (bytes_sent)
  );

  assign m_axis_tdata = {bytes_sent, frames_sent, out_byte};
  assign m_axis_tuser = {frame_end, status};

endmodule
